[sv/mac_grid_velocity_sampler_top_macros.svh]
// ----------------------------------------------------------------------------
// mac grid velocity sampler assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MAC_GRID_VELOCITY_SAMPLER_TOP_MACROS_SVH
`define MAC_GRID_VELOCITY_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTH
// clocked assertion, switched off while reset is active
`define MGVS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mgvs assertion failed");
// clocked assertion that also holds during reset
`define MGVS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mgvs assertion failed");
`else
`define MGVS_ASSERT(lbl, clk, rstn, prop)
`define MGVS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/mgvs_pkg.sv]
// ----------------------------------------------------------------------------
// mgvs_pkg
// shared constants, command codes and the tap control struct
// ----------------------------------------------------------------------------
package mgvs_pkg;

    // default geometry
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_FRAC_BITS = 8;

    // fixed field widths
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 1;
    localparam int CMD_W  = 2;
    localparam int CELL_W = 6;
    localparam int VEL_W  = 16;
    localparam int POS_W  = 16;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'd0;
    localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'd1;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIVERGE = 2'd2;

    // tap order around the base cell: bit 0 is the column step, bit 1 the row step
    localparam logic [1:0] TAP_00 = 2'd0;
    localparam logic [1:0] TAP_10 = 2'd1;
    localparam logic [1:0] TAP_01 = 2'd2;
    localparam logic [1:0] TAP_11 = 2'd3;

    // control travelling with each memory read
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic div;
        logic ok_x;
        logic ok_y;
    } tap_ctl_t;

endpackage

[sv/mac_grid_velocity_sampler_top.sv]
// ----------------------------------------------------------------------------
// mac_grid_velocity_sampler_top
// staggered grid velocity store with bilinear sampling and divergence
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one command item: write a cell's
// x and y velocity, sample both components at a Q8.8 position, or take the
// divergence at a cell. Sample and divergence items give one result item on
// out_valid/out_stall; writes and the unused command give none.
// grid_cols and grid_rows are written through cfg_we/cfg_idx/cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// After reset both memories are zero filled, one entry a cycle, over all
// MAX_COLS*MAX_ROWS entries (4096 by default); in_stall is high throughout.
// A sample or divergence item walks four taps through the memory read ports,
// and no new item is taken until its sum has moved into the output register.
// The next item is taken while a finished result still waits in the output
// register; once that register is blocked by out_stall and a second result is
// ready, in_stall stays high until the result is taken.
// ----------------------------------------------------------------------------
`include "mac_grid_velocity_sampler_top_macros.svh"

module mac_grid_velocity_sampler_top #(
    parameter int MAX_COLS  = mgvs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS  = mgvs_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = mgvs_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mgvs_pkg::IDX_W-1:0]        cfg_idx,
    input  logic [mgvs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mgvs_pkg::CMD_W-1:0]        command,
    input  logic [mgvs_pkg::CELL_W-1:0]       cell_x,
    input  logic [mgvs_pkg::CELL_W-1:0]       cell_y,
    input  logic signed [mgvs_pkg::VEL_W-1:0] write_vel_x,
    input  logic signed [mgvs_pkg::VEL_W-1:0] write_vel_y,
    input  logic [mgvs_pkg::POS_W-1:0]        pos_x,
    input  logic [mgvs_pkg::POS_W-1:0]        pos_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mgvs_pkg::VEL_W-1:0] result_x,
    output logic signed [mgvs_pkg::VEL_W-1:0] result_y
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CXW   = $clog2(MAX_COLS + 1);
    localparam int RYW   = $clog2(MAX_ROWS + 1);
    localparam int WTW   = 2 * FRAC_BITS + 2;
    localparam int CCW   = (mgvs_pkg::CFG_W > CXW) ? mgvs_pkg::CFG_W : CXW;
    localparam int RCW   = (mgvs_pkg::CFG_W > RYW) ? mgvs_pkg::CFG_W : RYW;
    localparam int MCW   = (mgvs_pkg::CELL_W > CXW) ? mgvs_pkg::CELL_W : CXW;
    localparam int MRW   = (mgvs_pkg::CELL_W > RYW) ? mgvs_pkg::CELL_W : RYW;

    logic [mgvs_pkg::CFG_W-1:0] cols_reg;
    logic [mgvs_pkg::CFG_W-1:0] rows_reg;
    logic [CCW-1:0] cols_w;
    logic [RCW-1:0] rows_w;
    logic [CXW-1:0] cols_eff;
    logic [RYW-1:0] rows_eff;

    logic          in_take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          start;
    logic          div_in;
    logic          clr_busy;
    logic          seq_busy;
    logic          acc_busy;
    logic [AW-1:0] rd_addr_x;
    logic [AW-1:0] rd_addr_y;
    logic [mgvs_pkg::VEL_W-1:0] rd_x;
    logic [mgvs_pkg::VEL_W-1:0] rd_y;
    mgvs_pkg::tap_ctl_t    ctl;
    logic signed [WTW-1:0] wx;
    logic signed [WTW-1:0] wy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= mgvs_pkg::GRID_RESET;
            rows_reg <= mgvs_pkg::GRID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                mgvs_pkg::REG_GRID_COLS: cols_reg <= cfg_data;
                mgvs_pkg::REG_GRID_ROWS: rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective grid size, limited to two and the memory size
    always_comb
    begin
        cols_w = CCW'(cols_reg);
        rows_w = RCW'(rows_reg);
        if (cols_w < CCW'(2))
        begin
            cols_eff = CXW'(2);
        end
        else if (cols_w > CCW'(MAX_COLS))
        begin
            cols_eff = CXW'(MAX_COLS);
        end
        else
        begin
            cols_eff = cols_w[CXW-1:0];
        end
        if (rows_w < RCW'(2))
        begin
            rows_eff = RYW'(2);
        end
        else if (rows_w > RCW'(MAX_ROWS))
        begin
            rows_eff = RYW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_w[RYW-1:0];
        end
    end

    // item acceptance and command decode
    always_comb
    begin
        in_stall = clr_busy | seq_busy | ctl.vld | acc_busy;
        in_take  = in_valid & !in_stall;
        wr_en    = in_take && (command == mgvs_pkg::CMD_WRITE)
                   && (MCW'(cell_x) < MCW'(MAX_COLS))
                   && (MRW'(cell_y) < MRW'(MAX_ROWS));
        wr_addr  = AW'(cell_y) * AW'(MAX_COLS) + AW'(cell_x);
        start    = in_take && ((command == mgvs_pkg::CMD_SAMPLE)
                   || (command == mgvs_pkg::CMD_DIVERGE));
        div_in   = (command == mgvs_pkg::CMD_DIVERGE);
    end

    mgvs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_x      (write_vel_x),
        .wr_y      (write_vel_y),
        .rd_addr_x (rd_addr_x),
        .rd_addr_y (rd_addr_y),
        .rd_x      (rd_x),
        .rd_y      (rd_y),
        .clr_busy  (clr_busy)
    );

    mgvs_seq #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS),
        .CXW       (CXW),
        .RYW       (RYW),
        .AW        (AW),
        .WTW       (WTW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .div_in    (div_in),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .cols_eff  (cols_eff),
        .rows_eff  (rows_eff),
        .busy      (seq_busy),
        .rd_addr_x (rd_addr_x),
        .rd_addr_y (rd_addr_y),
        .ctl       (ctl),
        .wx        (wx),
        .wy        (wy)
    );

    mgvs_acc #(
        .FRAC_BITS (FRAC_BITS),
        .WTW       (WTW)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wx        (wx),
        .wy        (wy),
        .rd_x      (rd_x),
        .rd_y      (rd_y),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result_x  (result_x),
        .result_y  (result_y),
        .busy      (acc_busy)
    );

    // no item is taken while the memories are being filled
    `MGVS_ASSERT_ALWAYS(a_top_fill_stalls, clk, clr_busy |-> in_stall)

endmodule

[sv/mgvs_store.sv]
// ----------------------------------------------------------------------------
// mgvs_store
// x and y velocity memories with one write and one registered read each,
// plus the zero fill pass after reset
// ----------------------------------------------------------------------------
module mgvs_store #(
    parameter int DEPTH = mgvs_pkg::DEF_MAX_COLS * mgvs_pkg::DEF_MAX_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [mgvs_pkg::VEL_W-1:0] wr_x,
    input  logic [mgvs_pkg::VEL_W-1:0] wr_y,
    input  logic [AW-1:0]              rd_addr_x,
    input  logic [AW-1:0]              rd_addr_y,
    output logic [mgvs_pkg::VEL_W-1:0] rd_x,
    output logic [mgvs_pkg::VEL_W-1:0] rd_y,
    output logic                       clr_busy
);

    logic [mgvs_pkg::VEL_W-1:0] x_mem [DEPTH];
    logic [mgvs_pkg::VEL_W-1:0] y_mem [DEPTH];

    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [mgvs_pkg::VEL_W-1:0] mem_wx;
    logic [mgvs_pkg::VEL_W-1:0] mem_wy;

    // fill sweep, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // write port select
    always_comb
    begin
        mem_we = clr_reg | wr_en;
        mem_wa = clr_reg ? clr_addr_reg : wr_addr;
        mem_wx = clr_reg ? '0 : wr_x;
        mem_wy = clr_reg ? '0 : wr_y;
    end

    // x memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[mem_wa] <= mem_wx;
        end
        rd_x <= x_mem[rd_addr_x];
    end

    // y memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            y_mem[mem_wa] <= mem_wy;
        end
        rd_y <= y_mem[rd_addr_y];
    end

    assign clr_busy = clr_reg;

endmodule

[sv/mgvs_seq.sv]
// ----------------------------------------------------------------------------
// mgvs_seq
// takes a sample or divergence item, clamps its coordinates and issues the
// four reads of each memory with their weights, one tap a cycle
// ----------------------------------------------------------------------------
`include "mac_grid_velocity_sampler_top_macros.svh"

module mgvs_seq #(
    parameter int MAX_COLS  = mgvs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS  = mgvs_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = mgvs_pkg::DEF_FRAC_BITS,
    parameter int CXW       = $clog2(MAX_COLS + 1),
    parameter int RYW       = $clog2(MAX_ROWS + 1),
    parameter int AW        = $clog2(MAX_COLS * MAX_ROWS),
    parameter int WTW       = 2 * FRAC_BITS + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        div_in,
    input  logic [mgvs_pkg::CELL_W-1:0] cell_x,
    input  logic [mgvs_pkg::CELL_W-1:0] cell_y,
    input  logic [mgvs_pkg::POS_W-1:0]  pos_x,
    input  logic [mgvs_pkg::POS_W-1:0]  pos_y,
    input  logic [CXW-1:0]              cols_eff,
    input  logic [RYW-1:0]              rows_eff,
    output logic                        busy,
    output logic [AW-1:0]               rd_addr_x,
    output logic [AW-1:0]               rd_addr_y,
    output mgvs_pkg::tap_ctl_t          ctl,
    output logic signed [WTW-1:0]       wx,
    output logic signed [WTW-1:0]       wy
);

    localparam int F   = FRAC_BITS;
    localparam int FW  = F + 1;
    localparam int WXW = (mgvs_pkg::POS_W > CXW + F) ? mgvs_pkg::POS_W : CXW + F;
    localparam int WYW = (mgvs_pkg::POS_W > RYW + F) ? mgvs_pkg::POS_W : RYW + F;
    localparam int CCW = (mgvs_pkg::CELL_W > CXW) ? mgvs_pkg::CELL_W : CXW;
    localparam int RCW = (mgvs_pkg::CELL_W > RYW) ? mgvs_pkg::CELL_W : RYW;
    localparam logic [FW-1:0] ONE = FW'(1) << F;
    localparam logic signed [WTW-1:0] ONE2 = WTW'(1) << (2 * F);
    localparam logic signed [WTW-1:0] NEG2 = -ONE2;
    localparam logic [1:0] TAP_FIRST = mgvs_pkg::TAP_00;

    // latched item
    logic           busy_reg;
    logic [1:0]     tap_reg;
    logic           div_reg;
    logic [CXW-1:0] xi_reg;
    logic [RYW-1:0] xj_reg;
    logic [F-1:0]   xfx_reg;
    logic [F-1:0]   xfy_reg;
    logic [CXW-1:0] yi_reg;
    logic [RYW-1:0] yj_reg;
    logic [F-1:0]   yfx_reg;
    logic [F-1:0]   yfy_reg;

    mgvs_pkg::tap_ctl_t   ctl_reg;
    logic signed [WTW-1:0] wx_reg;
    logic signed [WTW-1:0] wy_reg;

    // clamp signals
    logic [WXW-1:0] wmax;
    logic [WXW-1:0] px_w;
    logic [WXW-1:0] pxc;
    logic [WXW-1:0] sxc;
    logic [WYW-1:0] hmax;
    logic [WYW-1:0] py_w;
    logic [WYW-1:0] pyc;
    logic [WYW-1:0] syc;
    logic [CCW-1:0] cx_w;
    logic [CCW-1:0] cx_max;
    logic [CCW-1:0] cxc;
    logic [RCW-1:0] cy_w;
    logic [RCW-1:0] cy_max;
    logic [RCW-1:0] cyc;

    // tap signals
    logic           dx;
    logic           dy;
    logic [CXW-1:0] col_x;
    logic [RYW-1:0] row_x;
    logic [CXW-1:0] col_y;
    logic [RYW-1:0] row_y;
    logic [FW-1:0]  ax_x;
    logic [FW-1:0]  ay_x;
    logic [FW-1:0]  ax_y;
    logic [FW-1:0]  ay_y;
    logic [WTW-1:0] ws_x;
    logic [WTW-1:0] ws_y;
    mgvs_pkg::tap_ctl_t   ctl_next;
    logic signed [WTW-1:0] wx_next;
    logic signed [WTW-1:0] wy_next;

    // clamp the position to the extent and shift by half a cell
    always_comb
    begin
        wmax = WXW'(cols_eff - CXW'(1)) << F;
        px_w = WXW'(pos_x);
        pxc  = (px_w > wmax) ? wmax : px_w;
        sxc  = (pxc >= (WXW'(1) << (F - 1))) ? pxc - (WXW'(1) << (F - 1)) : '0;
        hmax = WYW'(rows_eff - RYW'(1)) << F;
        py_w = WYW'(pos_y);
        pyc  = (py_w > hmax) ? hmax : py_w;
        syc  = (pyc >= (WYW'(1) << (F - 1))) ? pyc - (WYW'(1) << (F - 1)) : '0;
        cx_w   = CCW'(cell_x);
        cx_max = CCW'(cols_eff - CXW'(1));
        cxc    = (cx_w > cx_max) ? cx_max : cx_w;
        cy_w   = RCW'(cell_y);
        cy_max = RCW'(rows_eff - RYW'(1));
        cyc    = (cy_w > cy_max) ? cy_max : cy_w;
    end

    // tap address, range check and weight
    always_comb
    begin
        dx    = tap_reg[0];
        dy    = tap_reg[1];
        col_x = xi_reg + CXW'(dx);
        row_x = xj_reg + RYW'(dy);
        col_y = yi_reg + CXW'(dx);
        row_y = yj_reg + RYW'(dy);
        rd_addr_x = AW'(row_x) * AW'(MAX_COLS) + AW'(col_x);
        rd_addr_y = AW'(row_y) * AW'(MAX_COLS) + AW'(col_y);
        ax_x = dx ? {1'b0, xfx_reg} : ONE - {1'b0, xfx_reg};
        ay_x = dy ? {1'b0, xfy_reg} : ONE - {1'b0, xfy_reg};
        ax_y = dx ? {1'b0, yfx_reg} : ONE - {1'b0, yfx_reg};
        ay_y = dy ? {1'b0, yfy_reg} : ONE - {1'b0, yfy_reg};
        ws_x = ax_x * ay_x;
        ws_y = ax_y * ay_y;

        ctl_next.vld   = busy_reg;
        ctl_next.first = (tap_reg == TAP_FIRST);
        ctl_next.last  = (tap_reg == mgvs_pkg::TAP_11);
        ctl_next.div   = div_reg;
        ctl_next.ok_x  = (col_x < cols_eff) && (row_x < rows_eff);
        ctl_next.ok_y  = (col_y < cols_eff) && (row_y < rows_eff);

        if (div_reg)
        begin
            case (tap_reg)
                mgvs_pkg::TAP_00:
                begin
                    wx_next = NEG2;
                    wy_next = NEG2;
                end
                mgvs_pkg::TAP_10:
                begin
                    wx_next = ONE2;
                    wy_next = '0;
                end
                mgvs_pkg::TAP_01:
                begin
                    wx_next = '0;
                    wy_next = ONE2;
                end
                default:
                begin
                    wx_next = '0;
                    wy_next = '0;
                end
            endcase
        end
        else
        begin
            wx_next = $signed(ws_x);
            wy_next = $signed(ws_y);
        end
    end

    // item latch and tap counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            tap_reg  <= mgvs_pkg::TAP_00;
            ctl_reg  <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (busy_reg)
            begin
                tap_reg <= tap_reg + 2'd1;
                if (tap_reg == mgvs_pkg::TAP_11)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                tap_reg  <= mgvs_pkg::TAP_00;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wx_reg <= wx_next;
        wy_reg <= wy_next;
        if (start && !busy_reg)
        begin
            div_reg <= div_in;
            if (div_in)
            begin
                xi_reg  <= cxc[CXW-1:0];
                xj_reg  <= cyc[RYW-1:0];
                yi_reg  <= cxc[CXW-1:0];
                yj_reg  <= cyc[RYW-1:0];
                xfx_reg <= '0;
                xfy_reg <= '0;
                yfx_reg <= '0;
                yfy_reg <= '0;
            end
            else
            begin
                xi_reg  <= pxc[F +: CXW];
                xfx_reg <= pxc[F-1:0];
                xj_reg  <= syc[F +: RYW];
                xfy_reg <= syc[F-1:0];
                yi_reg  <= sxc[F +: CXW];
                yfx_reg <= sxc[F-1:0];
                yj_reg  <= pyc[F +: RYW];
                yfy_reg <= pyc[F-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign ctl  = ctl_reg;
    assign wx   = wx_reg;
    assign wy   = wy_reg;

    // four taps then idle
    `MGVS_ASSERT(a_seq_four_taps, clk, rst_n, busy_reg && tap_reg == mgvs_pkg::TAP_11 |=> !busy_reg)
    `MGVS_ASSERT(a_seq_last_tagged, clk, rst_n, busy_reg && tap_reg == mgvs_pkg::TAP_11 |=> ctl_reg.vld && ctl_reg.last)

endmodule

[sv/mgvs_acc.sv]
// ----------------------------------------------------------------------------
// mgvs_acc
// weights each read value, accumulates the four taps, rounds, saturates
// and holds the result item in the output register
// ----------------------------------------------------------------------------
`include "mac_grid_velocity_sampler_top_macros.svh"

module mgvs_acc #(
    parameter int FRAC_BITS = mgvs_pkg::DEF_FRAC_BITS,
    parameter int WTW       = 2 * FRAC_BITS + 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mgvs_pkg::tap_ctl_t                ctl,
    input  logic signed [WTW-1:0]             wx,
    input  logic signed [WTW-1:0]             wy,
    input  logic [mgvs_pkg::VEL_W-1:0]        rd_x,
    input  logic [mgvs_pkg::VEL_W-1:0]        rd_y,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic signed [mgvs_pkg::VEL_W-1:0] result_x,
    output logic signed [mgvs_pkg::VEL_W-1:0] result_y,
    output logic                              busy
);

    localparam int PW   = mgvs_pkg::VEL_W + WTW;
    localparam int ACCW = PW + 3;
    localparam logic signed [ACCW-1:0] RND  = ACCW'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [ACCW-1:0] SMAX = ACCW'(32767);
    localparam logic signed [ACCW-1:0] SMIN = -ACCW'(32768);

    mgvs_pkg::tap_ctl_t    c_ctl_reg;
    logic signed [PW-1:0]  prod_x_reg;
    logic signed [PW-1:0]  prod_y_reg;
    logic signed [ACCW-1:0] acc_x_reg;
    logic signed [ACCW-1:0] acc_y_reg;
    logic                  pend_reg;
    logic                  div_reg;
    logic                  out_valid_reg;
    logic signed [mgvs_pkg::VEL_W-1:0] result_x_reg;
    logic signed [mgvs_pkg::VEL_W-1:0] result_y_reg;

    logic signed [PW-1:0]   prod_x_next;
    logic signed [PW-1:0]   prod_y_next;
    logic signed [ACCW-1:0] sum_x;
    logic signed [ACCW-1:0] rnd_x;
    logic signed [ACCW-1:0] rnd_y;
    logic signed [ACCW-1:0] sh_x;
    logic signed [ACCW-1:0] sh_y;
    logic signed [mgvs_pkg::VEL_W-1:0] sat_x;
    logic signed [mgvs_pkg::VEL_W-1:0] sat_y;
    logic                  finish;

    // weighted read value, missing neighbours read as zero
    always_comb
    begin
        prod_x_next = '0;
        prod_y_next = '0;
        if (ctl.ok_x)
        begin
            prod_x_next = $signed(rd_x) * wx;
        end
        if (ctl.ok_y)
        begin
            prod_y_next = $signed(rd_y) * wy;
        end
    end

    // round to nearest, ties up, then saturate
    always_comb
    begin
        sum_x = div_reg ? acc_x_reg + acc_y_reg : acc_x_reg;
        rnd_x = sum_x + RND;
        rnd_y = acc_y_reg + RND;
        sh_x  = rnd_x >>> (2 * FRAC_BITS);
        sh_y  = rnd_y >>> (2 * FRAC_BITS);
        if (sh_x > SMAX)
        begin
            sat_x = 16'sh7fff;
        end
        else if (sh_x < SMIN)
        begin
            sat_x = -16'sh8000;
        end
        else
        begin
            sat_x = sh_x[mgvs_pkg::VEL_W-1:0];
        end
        if (div_reg)
        begin
            sat_y = '0;
        end
        else if (sh_y > SMAX)
        begin
            sat_y = 16'sh7fff;
        end
        else if (sh_y < SMIN)
        begin
            sat_y = -16'sh8000;
        end
        else
        begin
            sat_y = sh_y[mgvs_pkg::VEL_W-1:0];
        end
        finish = pend_reg && (!out_valid_reg || !out_stall);
    end

    // control: product stage valid, pending sum, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_ctl_reg <= ctl;
            if (c_ctl_reg.vld && c_ctl_reg.last)
            begin
                pend_reg <= 1'b1;
            end
            else if (finish)
            begin
                pend_reg <= 1'b0;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        if (c_ctl_reg.vld)
        begin
            div_reg <= c_ctl_reg.div;
            if (c_ctl_reg.first)
            begin
                acc_x_reg <= ACCW'(prod_x_reg);
                acc_y_reg <= ACCW'(prod_y_reg);
            end
            else
            begin
                acc_x_reg <= acc_x_reg + ACCW'(prod_x_reg);
                acc_y_reg <= acc_y_reg + ACCW'(prod_y_reg);
            end
        end
        if (finish)
        begin
            result_x_reg <= sat_x;
            result_y_reg <= sat_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_x  = result_x_reg;
    assign result_y  = result_y_reg;
    assign busy      = c_ctl_reg.vld | pend_reg;

    // last tap always leaves a pending sum
    `MGVS_ASSERT(a_acc_last_pends, clk, rst_n, c_ctl_reg.vld && c_ctl_reg.last |=> pend_reg)
    // a pending sum waits while the output register is blocked
    `MGVS_ASSERT(a_acc_pend_holds, clk, rst_n, pend_reg && out_valid_reg && out_stall |=> pend_reg)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives write, sample, divergence and unused commands into the staggered-grid
// velocity sampler. A scoreboard keeps its own copy of both velocity stores
// and the grid size, works out each result, and compares it field by field
// with what the block returns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NCOLS = mgvs_pkg::DEF_MAX_COLS;
    localparam int NROWS = mgvs_pkg::DEF_MAX_ROWS;
    localparam int FB    = mgvs_pkg::DEF_FRAC_BITS;

    typedef logic [mgvs_pkg::CMD_W-1:0] cmd_t;

    typedef struct packed {
        logic [mgvs_pkg::CMD_W-1:0]  cmd;
        logic [mgvs_pkg::CELL_W-1:0] cx;
        logic [mgvs_pkg::CELL_W-1:0] cy;
        logic [mgvs_pkg::VEL_W-1:0]  vx;
        logic [mgvs_pkg::VEL_W-1:0]  vy;
        logic [mgvs_pkg::POS_W-1:0]  px;
        logic [mgvs_pkg::POS_W-1:0]  py;
    } grid_item_t;

    typedef struct packed {
        logic [mgvs_pkg::VEL_W-1:0] rx;
        logic [mgvs_pkg::VEL_W-1:0] ry;
    } vel_pair_t;

    // grid model and queue of expected velocity pairs
    class velocity_scoreboard;
        logic [mgvs_pkg::VEL_W-1:0] xmem [NCOLS*NROWS];
        logic [mgvs_pkg::VEL_W-1:0] ymem [NCOLS*NROWS];
        int unsigned      cols_reg;
        int unsigned      rows_reg;
        vel_pair_t        pending [$];
        int               errors;
        int               n_results;

        function void clear_grid();
            foreach (xmem[k])
            begin
                xmem[k] = '0;
                ymem[k] = '0;
            end
            cols_reg  = 64;
            rows_reg  = 64;
            errors    = 0;
            n_results = 0;
        endfunction

        function void set_reg(logic [mgvs_pkg::IDX_W-1:0] idx,
                              logic [mgvs_pkg::CFG_W-1:0] val);
            if (idx == mgvs_pkg::REG_GRID_COLS)
                cols_reg = val;
            else
                rows_reg = val;
        endfunction

        function int unsigned active(int unsigned v, int unsigned m);
            if (v < 2)
                return 2;
            if (v > m)
                return m;
            return v;
        endfunction

        function longint cell_vel(bit use_y, int unsigned x, int unsigned y,
                                  int unsigned c, int unsigned r);
            logic signed [mgvs_pkg::VEL_W-1:0] w;
            if (x >= c || y >= r)
                return 0;
            w = use_y ? ymem[y*NCOLS + x] : xmem[y*NCOLS + x];
            return longint'(w);
        endfunction

        function logic [mgvs_pkg::VEL_W-1:0] clip16(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[mgvs_pkg::VEL_W-1:0];
        endfunction

        function logic [mgvs_pkg::VEL_W-1:0] bilinear(bit use_y, int unsigned px,
                                                      int unsigned py,
                                                      int unsigned c, int unsigned r);
            int unsigned i, j;
            longint fx, fy, gx, gy, s;
            i  = px >> FB;
            j  = py >> FB;
            fx = px & ((1 << FB) - 1);
            fy = py & ((1 << FB) - 1);
            gx = (1 << FB) - fx;
            gy = (1 << FB) - fy;
            s  = gx*gy*cell_vel(use_y, i, j, c, r) + fx*gy*cell_vel(use_y, i+1, j, c, r)
               + gx*fy*cell_vel(use_y, i, j+1, c, r)
               + fx*fy*cell_vel(use_y, i+1, j+1, c, r);
            s += longint'(1) << (2*FB - 1);
            return clip16(s >>> (2*FB));
        endfunction

        // apply one accepted item, queue its result if it gives one
        function void note_item(grid_item_t it);
            int unsigned c, r, px, py, cx, cy;
            vel_pair_t   e;
            longint      d;
            c = active(cols_reg, NCOLS);
            r = active(rows_reg, NROWS);
            if (it.cmd == mgvs_pkg::CMD_WRITE)
            begin
                xmem[it.cy*NCOLS + it.cx] = it.vx;
                ymem[it.cy*NCOLS + it.cx] = it.vy;
            end
            else if (it.cmd == mgvs_pkg::CMD_SAMPLE)
            begin
                px = it.px;
                py = it.py;
                if (px > ((c-1) << FB))
                    px = (c-1) << FB;
                if (py > ((r-1) << FB))
                    py = (r-1) << FB;
                e.rx = bilinear(0, px, (py >= (1 << (FB-1))) ? py - (1 << (FB-1)) : 0, c, r);
                e.ry = bilinear(1, (px >= (1 << (FB-1))) ? px - (1 << (FB-1)) : 0, py, c, r);
                pending.push_back(e);
            end
            else if (it.cmd == mgvs_pkg::CMD_DIVERGE)
            begin
                cx = (it.cx > c-1) ? c-1 : it.cx;
                cy = (it.cy > r-1) ? r-1 : it.cy;
                d  = cell_vel(0, cx+1, cy, c, r) - cell_vel(0, cx, cy, c, r)
                   + cell_vel(1, cx, cy+1, c, r) - cell_vel(1, cx, cy, c, r);
                e.rx = clip16(d);
                e.ry = '0;
                pending.push_back(e);
            end
        endfunction

        function void check_result(vel_pair_t got);
            vel_pair_t e;
            n_results++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h", $time, got.rx, got.ry);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.rx !== e.rx)
            begin
                $display("%0t: result_x expected %h actual %h", $time, e.rx, got.rx);
                errors++;
            end
            if (got.ry !== e.ry)
            begin
                $display("%0t: result_y expected %h actual %h", $time, e.ry, got.ry);
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [mgvs_pkg::IDX_W-1:0]        cfg_idx = '0;
    logic [mgvs_pkg::CFG_W-1:0]        cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [mgvs_pkg::CMD_W-1:0]        command = '0;
    logic [mgvs_pkg::CELL_W-1:0]       cell_x = '0;
    logic [mgvs_pkg::CELL_W-1:0]       cell_y = '0;
    logic signed [mgvs_pkg::VEL_W-1:0] write_vel_x = '0;
    logic signed [mgvs_pkg::VEL_W-1:0] write_vel_y = '0;
    logic [mgvs_pkg::POS_W-1:0]        pos_x = '0;
    logic [mgvs_pkg::POS_W-1:0]        pos_y = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [mgvs_pkg::VEL_W-1:0] result_x;
    logic signed [mgvs_pkg::VEL_W-1:0] result_y;

    velocity_scoreboard sb;
    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    int n_items = 0;

    mac_grid_velocity_sampler_top dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: stall at random, check each taken result
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < dst_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{result_x, result_y});
    end

    // drive one item and hold it until taken; valid stays up for the next one
    task automatic send_item(grid_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= it.cmd;
        cell_x      <= it.cx;
        cell_y      <= it.cy;
        write_vel_x <= it.vx;
        write_vel_y <= it.vy;
        pos_x       <= it.px;
        pos_y       <= it.py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        n_items++;
        @(negedge clk);
    endtask

    // drop valid, wait for all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // the caller drops the write enable after its last write
    task automatic write_reg(logic [mgvs_pkg::IDX_W-1:0] idx,
                             logic [mgvs_pkg::CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    function automatic grid_item_t rand_item(bit in_grid);
        grid_item_t  it;
        int unsigned k;
        int unsigned c;
        int unsigned r;
        int unsigned v;
        logic [127:0] rbits;
        rbits = {$urandom, $urandom, $urandom, $urandom};
        it = rbits[$bits(grid_item_t)-1:0];
        k  = $urandom_range(99);
        it.cmd = (k < 40) ? mgvs_pkg::CMD_WRITE : (k < 75) ? mgvs_pkg::CMD_SAMPLE
               : (k < 97) ? mgvs_pkg::CMD_DIVERGE : cmd_t'(3);
        if (in_grid)
        begin
            c = sb.active(sb.cols_reg, NCOLS);
            r = sb.active(sb.rows_reg, NROWS);
            v = $urandom_range(c);
            it.cx = v[mgvs_pkg::CELL_W-1:0];
            v = $urandom_range(r);
            it.cy = v[mgvs_pkg::CELL_W-1:0];
            v = $urandom_range(c << FB);
            it.px = v[mgvs_pkg::POS_W-1:0];
            v = $urandom_range(r << FB);
            it.py = v[mgvs_pkg::POS_W-1:0];
        end
        if ($urandom_range(9) == 0)
            it.vx = $urandom_range(1) ? 16'h7fff : 16'h8000;
        if ($urandom_range(9) == 0)
            it.vy = $urandom_range(1) ? 16'h7fff : 16'h8000;
        return it;
    endfunction

    function automatic grid_item_t mk(cmd_t c, int x, int y, int vx, int vy,
                                      int px, int py);
        grid_item_t it;
        it.cmd = c;
        it.cx = x[mgvs_pkg::CELL_W-1:0];
        it.cy = y[mgvs_pkg::CELL_W-1:0];
        it.vx = vx[mgvs_pkg::VEL_W-1:0];
        it.vy = vy[mgvs_pkg::VEL_W-1:0];
        it.px = px[mgvs_pkg::POS_W-1:0];
        it.py = py[mgvs_pkg::POS_W-1:0];
        return it;
    endfunction

    initial
    begin
        int cfg_sets [6][2] = '{'{64, 64}, '{2, 2}, '{5, 9}, '{127, 0}, '{33, 64}, '{64, 17}};
        int idle_src [4] = '{0, 86, 0, 33};
        int idle_dst [4] = '{0, 0, 86, 33};
        logic [31:0] cv;
        sb = new();
        sb.clear_grid();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, saturation, border cells, unused command
        send_item(mk(mgvs_pkg::CMD_WRITE, 0, 0, 32767, -32768, 0, 0));
        send_item(mk(mgvs_pkg::CMD_WRITE, 1, 0, -32768, 32767, 0, 0));
        send_item(mk(mgvs_pkg::CMD_WRITE, 0, 1, -32768, -32768, 0, 0));
        send_item(mk(mgvs_pkg::CMD_WRITE, 63, 63, 32767, 32767, 0, 0));
        send_item(mk(mgvs_pkg::CMD_WRITE, 62, 63, -1, 1, 0, 0));
        send_item(mk(mgvs_pkg::CMD_DIVERGE, 0, 0, 0, 0, 0, 0));
        send_item(mk(mgvs_pkg::CMD_DIVERGE, 63, 63, 0, 0, 0, 0));
        send_item(mk(mgvs_pkg::CMD_DIVERGE, 62, 63, 0, 0, 0, 0));
        send_item(mk(mgvs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0));
        send_item(mk(mgvs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 128, 128));
        send_item(mk(mgvs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 127, 383));
        send_item(mk(mgvs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 65535, 65535));
        send_item(mk(mgvs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 16256, 16255));
        send_item(mk(cmd_t'(3), 63, 63, -1, -1, 65535, 65535));
        send_item(mk(mgvs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 200, 77));
        drain();

        // random phases across grid sizes and idling patterns
        for (int p = 0; p < 12; p++)
        begin
            cv = cfg_sets[p % 6][0];
            write_reg(mgvs_pkg::REG_GRID_COLS, cv[mgvs_pkg::CFG_W-1:0]);
            cv = cfg_sets[p % 6][1];
            write_reg(mgvs_pkg::REG_GRID_ROWS, cv[mgvs_pkg::CFG_W-1:0]);
            cfg_we <= 1'b0;
            src_idle_pct  = idle_src[p % 4];
            dst_stall_pct = idle_dst[p % 4];
            for (int n = 0; n < 53; n++)
                send_item(rand_item($urandom_range(3) != 0));
            drain();
        end
        dst_stall_pct = 0;
        drain();

        $display("ran %0d items, checked %0d results over 6 grid sizes and 4 idling patterns",
                 n_items, sb.n_results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/mgvs_pkg.sv
sv/mgvs_store.sv
sv/mgvs_seq.sv
sv/mgvs_acc.sv
sv/mac_grid_velocity_sampler_top.sv
dv/tb_top.sv
